// ===== hw/rtl/mssd_pkg.sv =====
// ----------------------------------------------------------------------------
// mssd_pkg: shared types and constants of the system stream demultiplexer
// Result kinds, error bits, parse modes and the queue entry format.
// ----------------------------------------------------------------------------
package mssd_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned QueueCntW  = 2;

  localparam logic [15:0] GapReset = 16'd600;

  typedef enum logic [1:0] {
    KIND_AUDIO = 2'd0,
    KIND_VIDEO = 2'd1,
    KIND_EVENT = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  localparam logic [1:0] ErrNone      = 2'd0;
  localparam logic [1:0] ErrBadMarker = 2'd1;
  localparam logic [1:0] ErrShort     = 2'd2;

  typedef enum logic [7:0] {
    M_SCAN    = 8'b0000_0001,
    M_LEN_HI  = 8'b0000_0010,
    M_LEN_LO  = 8'b0000_0100,
    M_FLAGS   = 8'b0000_1000,
    M_STD_LOW = 8'b0001_0000,
    M_MARKER  = 8'b0010_0000,
    M_SKIP    = 8'b0100_0000,
    M_PAYLOAD = 8'b1000_0000
  } mode_t;

  // One classified beat, waiting in the queue for the back end.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [4:0] stream;
    logic [1:0] err;
  } entry_t;

endpackage

// ===== hw/rtl/mpeg1_system_stream_demux_core.sv =====
// A result beat passes through the queue and then the result register.
// Throughput: one stream byte per cycle while the queue is not full; the
// header parser handles every byte as it arrives, and the two-entry queue
// absorbs short output stalls. Reset: synchronous, active low; min_frame_gap
// returns to 600 and parsing restarts by scanning for a start code.
// ----------------------------------------------------------------------------
// mpeg1_system_stream_demux_core: MPEG-1 system stream demultiplexer
// Finds start codes, parses audio and video packet headers and passes event,
// error and payload beats out with stream number and audio frame start flag.
// ----------------------------------------------------------------------------
module mpeg1_system_stream_demux_core #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [4:0]  out_stream_number,
  output logic [1:0]  out_error_kind,
  output logic        out_frame_start,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import mssd_pkg::*;

  logic        gap_wr;
  logic [15:0] gap_r, gap_nxt;

  logic        in_accept;
  logic        push;
  entry_t      push_entry;
  logic        pop;
  logic        full;
  logic        head_valid;
  entry_t      head_entry;

  assign cfg_pready = 1'b1;
  assign gap_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == 1'b0);
  assign gap_nxt    = gap_wr ? cfg_pwdata[15:0] : gap_r;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {16'd0, gap_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= GapReset;
    end else begin
      gap_r <= gap_nxt;
    end
  end

  assign in_stall  = full;
  assign in_accept = in_valid && !full;

  mssd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_accept),
    .byte_in    (in_byte),
    .push       (push),
    .push_entry (push_entry)
  );

  mssd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  mssd_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .min_frame_gap     (gap_r),
    .head_valid        (head_valid),
    .head_entry        (head_entry),
    .pop               (pop),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_data_byte     (out_data_byte),
    .out_stream_number (out_stream_number),
    .out_error_kind    (out_error_kind),
    .out_frame_start   (out_frame_start)
  );

endmodule

// ===== hw/rtl/mssd_front.sv =====
// ----------------------------------------------------------------------------
// mssd_front: start code scanner and packet header parser
// Classifies every accepted stream byte and pushes events, errors and payload
// bytes into the queue.
// ----------------------------------------------------------------------------
module mssd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            byte_valid,
  input  logic [7:0]      byte_in,
  output logic            push,
  output mssd_pkg::entry_t push_entry
);
  import mssd_pkg::*;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  zrun_r, zrun_nxt;
  logic [15:0] plen_r, plen_nxt;
  logic [15:0] hused_r, hused_nxt;
  logic [3:0]  skip_r, skip_nxt;
  logic [15:0] pleft_r, pleft_nxt;
  logic        is_audio_r, is_audio_nxt;
  logic [4:0]  cur_r, cur_nxt;

  logic        in_header;
  logic [15:0] hu_inc;
  logic        eh_gt;
  logic [15:0] eh_left;
  logic [3:0]  skip_dec;
  logic [15:0] pleft_dec;
  logic        do_end;
  logic        end_bad;
  logic [1:0]  end_err;

  assign in_header = (mode_r == M_FLAGS) || (mode_r == M_STD_LOW) ||
                     (mode_r == M_MARKER) || (mode_r == M_SKIP);
  assign hu_inc    = (in_header && hused_r != 16'hFFFF) ? hused_r + 16'd1 : hused_r;
  assign eh_gt     = hu_inc > plen_r;
  assign eh_left   = plen_r - hu_inc;
  assign skip_dec  = (skip_r != 4'd0) ? skip_r - 4'd1 : skip_r;
  assign pleft_dec = (pleft_r != 16'd0) ? pleft_r - 16'd1 : pleft_r;
  assign end_err   = {eh_gt, end_bad};

  always_comb begin
    mode_nxt     = mode_r;
    zrun_nxt     = zrun_r;
    plen_nxt     = plen_r;
    hused_nxt    = hused_r;
    skip_nxt     = skip_r;
    pleft_nxt    = pleft_r;
    is_audio_nxt = is_audio_r;
    cur_nxt      = cur_r;
    push         = 1'b0;
    push_entry   = '{kind: KIND_EVENT, data: byte_in, stream: 5'd0, err: ErrNone};
    do_end       = 1'b0;
    end_bad      = 1'b0;
    if (byte_valid) begin
      hused_nxt = hu_inc;
      unique case (mode_r)
        M_SCAN: begin
          if (zrun_r == 2'd3) begin
            zrun_nxt = 2'd0;
            push     = 1'b1;
            if (byte_in[7:5] == 3'b110) begin
              is_audio_nxt      = 1'b1;
              cur_nxt           = byte_in[4:0];
              push_entry.stream = byte_in[4:0];
              mode_nxt          = M_LEN_HI;
            end else if (byte_in[7:4] == 4'hE) begin
              is_audio_nxt      = 1'b0;
              cur_nxt           = {1'b0, byte_in[3:0]};
              push_entry.stream = {1'b0, byte_in[3:0]};
              mode_nxt          = M_LEN_HI;
            end
          end else if (byte_in == 8'h00) begin
            if (zrun_r < 2'd2) zrun_nxt = zrun_r + 2'd1;
          end else if (byte_in == 8'h01 && zrun_r == 2'd2) begin
            zrun_nxt = 2'd3;
          end else begin
            zrun_nxt = 2'd0;
          end
        end
        M_LEN_HI: begin
          plen_nxt = {byte_in, 8'h00};
          mode_nxt = M_LEN_LO;
        end
        M_LEN_LO: begin
          plen_nxt  = {plen_r[15:8], byte_in};
          hused_nxt = 16'd0;
          mode_nxt  = M_FLAGS;
        end
        M_FLAGS, M_MARKER: begin
          if (mode_r == M_FLAGS && byte_in == 8'hFF) begin
            mode_nxt = M_FLAGS;
          end else if (mode_r == M_FLAGS && byte_in[7:6] == 2'b01) begin
            mode_nxt = M_STD_LOW;
          end else if (byte_in[7:4] == 4'h2) begin
            skip_nxt = 4'd4;
            mode_nxt = M_SKIP;
          end else if (byte_in[7:4] == 4'h3) begin
            skip_nxt = 4'd9;
            mode_nxt = M_SKIP;
          end else begin
            do_end  = 1'b1;
            end_bad = (byte_in != 8'h0F);
          end
        end
        M_STD_LOW: begin
          mode_nxt = M_MARKER;
        end
        M_SKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == 4'd0) do_end = 1'b1;
        end
        M_PAYLOAD: begin
          push       = 1'b1;
          push_entry = '{kind: (is_audio_r ? KIND_AUDIO : KIND_VIDEO), data: byte_in,
                         stream: cur_r, err: ErrNone};
          pleft_nxt  = pleft_dec;
          if (pleft_dec == 16'd0) begin
            mode_nxt = M_SCAN;
            zrun_nxt = 2'd0;
          end
        end
        default: begin
          mode_nxt = M_SCAN;
        end
      endcase
      // Header done: the length left over becomes the payload count.
      if (do_end) begin
        pleft_nxt = eh_gt ? 16'd0 : eh_left;
        zrun_nxt  = 2'd0;
        mode_nxt  = (!eh_gt && eh_left != 16'd0) ? M_PAYLOAD : M_SCAN;
        if (end_err != ErrNone) begin
          push       = 1'b1;
          push_entry = '{kind: KIND_ERROR, data: 8'h00, stream: cur_r, err: end_err};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= M_SCAN;
      zrun_r     <= 2'd0;
      plen_r     <= 16'd0;
      hused_r    <= 16'd0;
      skip_r     <= 4'd0;
      pleft_r    <= 16'd0;
      is_audio_r <= 1'b0;
      cur_r      <= 5'd0;
    end else begin
      mode_r     <= mode_nxt;
      zrun_r     <= zrun_nxt;
      plen_r     <= plen_nxt;
      hused_r    <= hused_nxt;
      skip_r     <= skip_nxt;
      pleft_r    <= pleft_nxt;
      is_audio_r <= is_audio_nxt;
      cur_r      <= cur_nxt;
    end
  end

endmodule

// ===== hw/rtl/mssd_fifo.sv =====
// ----------------------------------------------------------------------------
// mssd_fifo: short queue between the header parser and the back end
// Two entries; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module mssd_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mssd_pkg::entry_t push_entry,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output mssd_pkg::entry_t head_entry
);
  import mssd_pkg::*;

  entry_t                 mem_r [QueueDepth];
  logic [QueuePtrW-1:0]   wptr_r, wptr_nxt;
  logic [QueuePtrW-1:0]   rptr_r, rptr_nxt;
  logic [QueueCntW-1:0]   cnt_r, cnt_nxt;

  assign full       = (cnt_r == QueueCntW'(QueueDepth));
  assign head_valid = (cnt_r != '0);
  assign head_entry = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + QueueCntW'(push) - QueueCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/mssd_back.sv =====
// ----------------------------------------------------------------------------
// mssd_back: audio frame sync tracker and result register
// Takes queue entries, marks audio frame starts and holds the result beat.
// ----------------------------------------------------------------------------
module mssd_back #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [15:0]      min_frame_gap,
  input  logic             head_valid,
  input  mssd_pkg::entry_t head_entry,
  output logic             pop,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_data_byte,
  output logic [4:0]       out_stream_number,
  output logic [1:0]       out_error_kind,
  output logic             out_frame_start
);
  import mssd_pkg::*;

  logic [15:0]            shift_r, shift_nxt;
  // Audio byte count after the next audio byte, kept one ahead.
  logic [COUNT_WIDTH-1:0] cnt_next_r, cnt_next_nxt;
  logic [COUNT_WIDTH-1:0] last_sync_r, last_sync_nxt;
  logic                   valid_r, valid_nxt;
  entry_t                 res_r;
  logic                   fs_r;

  logic                   is_audio;
  logic [15:0]            shift_new;
  logic [COUNT_WIDTH-1:0] diff;
  logic                   sync_seen;
  logic                   fs;

  assign pop       = head_valid && (!valid_r || !out_stall);
  assign is_audio  = (head_entry.kind == KIND_AUDIO);
  assign shift_new = {shift_r[7:0], head_entry.data};
  assign diff      = cnt_next_r - last_sync_r;
  assign sync_seen = (shift_new[15:4] == 12'hFFF) || (shift_new[11:0] == 12'hFFF);
  assign fs        = is_audio && sync_seen && !diff[COUNT_WIDTH-1] &&
                     (diff > COUNT_WIDTH'(min_frame_gap));

  always_comb begin
    shift_nxt     = shift_r;
    cnt_next_nxt  = cnt_next_r;
    last_sync_nxt = last_sync_r;
    if (pop && is_audio) begin
      shift_nxt    = shift_new;
      cnt_next_nxt = cnt_next_r + COUNT_WIDTH'(1);
      if (fs) last_sync_nxt = cnt_next_r;
    end
    if (pop) valid_nxt = 1'b1;
    else if (out_stall) valid_nxt = valid_r;
    else valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= head_entry;
      fs_r  <= fs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r     <= 16'h5555;
      cnt_next_r  <= COUNT_WIDTH'(1);
      last_sync_r <= COUNT_WIDTH'(2);
      valid_r     <= 1'b0;
    end else begin
      shift_r     <= shift_nxt;
      cnt_next_r  <= cnt_next_nxt;
      last_sync_r <= last_sync_nxt;
      valid_r     <= valid_nxt;
    end
  end

  assign out_valid         = valid_r;
  assign out_kind          = res_r.kind;
  assign out_data_byte     = res_r.data;
  assign out_stream_number = res_r.stream;
  assign out_error_kind    = res_r.err;
  assign out_frame_start   = fs_r;

endmodule
